### sv/wav_riff_chunk_parser_core_assert.svh
// ----------------------------------------------------------------------------
// wav riff chunk parser assertion macros
// shared property forms for the parser's concurrent checks
// ----------------------------------------------------------------------------
`ifndef WAV_RIFF_CHUNK_PARSER_CORE_ASSERT_SVH
`define WAV_RIFF_CHUNK_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define WRCP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WRCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/wrcp_pkg.sv
// ----------------------------------------------------------------------------
// wrcp_pkg
// types and constants shared by the wav riff chunk parser
// ----------------------------------------------------------------------------
`default_nettype none

package wrcp_pkg;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_FORMAT = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_DONE   = 2'd3
   } wrcp_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_RIFF  = 3'd1,
      ERR_BAD_WAVE  = 3'd2,
      ERR_BAD_DEPTH = 3'd3,
      ERR_TRUNCATED = 3'd4
   } wrcp_err_type;

   typedef struct packed {
      wrcp_kind_type      kind;
      logic signed [15:0] sample;
      logic [15:0]        audio_format;
      logic [15:0]        channels;
      logic [31:0]        sample_rate;
      logic [31:0]        byte_rate;
      logic [15:0]        block_align;
      logic [15:0]        bits_per_sample;
      wrcp_err_type       error_code;
      logic               last;
   } wrcp_result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } wrcp_queue_status_type;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [3:0]  FMT_LAST_INDEX = 4'd15;
   localparam logic [15:0] PCM16_BITS     = 16'd16;
   localparam logic [32:0] POS_MAX        = 33'h1_FFFF_FFFF;
   localparam logic [32:0] SPAN_EXTRA     = 33'd8;

endpackage

`default_nettype wire

### sv/wrcp_if.sv
// ----------------------------------------------------------------------------
// wrcp stream interfaces
// byte request channel and result channel of the parser
// ----------------------------------------------------------------------------
`default_nettype none

interface wrcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       end_of_file;

   modport source (output valid, data_byte, first_byte, end_of_file, input ready);
   modport sink   (input valid, data_byte, first_byte, end_of_file, output ready);
endinterface

interface wrcp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] sample;
   logic [15:0]        audio_format;
   logic [15:0]        channels;
   logic [31:0]        sample_rate;
   logic [31:0]        byte_rate;
   logic [15:0]        block_align;
   logic [15:0]        bits_per_sample;
   logic [2:0]         error_code;
   logic               last;

   modport source (output valid, kind, sample, audio_format, channels, sample_rate,
                   byte_rate, block_align, bits_per_sample, error_code, last,
                   input ready);
   modport sink   (input valid, kind, sample, audio_format, channels, sample_rate,
                   byte_rate, block_align, bits_per_sample, error_code, last,
                   output ready);
endinterface

`default_nettype wire

### sv/wrcp_front.sv
// ----------------------------------------------------------------------------
// wrcp_front
// byte intake and riff/wave chunk walker; pushes one result per beat at most
// ----------------------------------------------------------------------------
`default_nettype none

module wrcp_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   wrcp_req_if.sink                            req_chan,
   input  wire wrcp_pkg::wrcp_queue_status_type q_status,
   output logic                                q_push,
   output wrcp_pkg::wrcp_result_type           q_push_data
);
   import wrcp_pkg::*;

   typedef enum logic [5:0] {
      PH_FILEHDR  = 6'b000001,
      PH_CHUNKHDR = 6'b000010,
      PH_FMT      = 6'b000100,
      PH_SKIP     = 6'b001000,
      PH_DATA     = 6'b010000,
      PH_HALT     = 6'b100000
   } wrcp_phase_type;

   wrcp_phase_type phase_ff, phase_in, cur_phase;
   logic [3:0]     hdr_cnt_ff, hdr_cnt_in, cur_hdr_cnt;
   logic [31:0]    riff_len_ff, riff_len_in, cur_riff_len;
   logic [32:0]    file_pos_ff, file_pos_in, cur_file_pos;
   logic [31:0]    tag_ff, tag_in, cur_tag;
   logic [31:0]    remain_ff, remain_in, cur_remain;
   logic [127:0]   fmt_ff, fmt_in, cur_fmt;
   logic [7:0]     low_ff, low_in, cur_low;
   logic           phase_bit_ff, phase_bit_in, cur_phase_bit;

   logic            accept;
   logic            restart;
   logic [7:0]      beat_byte;
   logic [32:0]     pos_inc;
   logic [31:0]     riff_upd;
   logic            span_done;
   logic [31:0]     tag_new;
   logic [31:0]     remain_new;
   logic [31:0]     remain_dec;
   logic            have;
   logic            err;
   logic            fin;
   wrcp_err_type    ecode;
   wrcp_result_type res;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign restart        = req_chan.first_byte;
   assign beat_byte      = req_chan.data_byte;

   // first beat of a new file sees cleared state
   assign cur_phase     = restart ? PH_FILEHDR : phase_ff;
   assign cur_hdr_cnt   = restart ? 4'd0 : hdr_cnt_ff;
   assign cur_riff_len  = restart ? 32'd0 : riff_len_ff;
   assign cur_file_pos  = restart ? 33'd0 : file_pos_ff;
   assign cur_tag       = restart ? 32'd0 : tag_ff;
   assign cur_remain    = restart ? 32'd0 : remain_ff;
   assign cur_fmt       = restart ? 128'd0 : fmt_ff;
   assign cur_low       = restart ? 8'd0 : low_ff;
   assign cur_phase_bit = restart ? 1'b0 : phase_bit_ff;

   assign pos_inc = (cur_file_pos == POS_MAX) ? cur_file_pos : cur_file_pos + 33'd1;

   always_comb begin
      riff_upd = cur_riff_len;
      if (cur_phase == PH_FILEHDR && cur_hdr_cnt[3:2] == 2'b01) begin
         riff_upd[{cur_hdr_cnt[1:0], 3'b000} +: 8] = beat_byte;
      end
   end

   assign span_done  = pos_inc >= ({1'b0, riff_upd} + SPAN_EXTRA);
   assign tag_new    = {cur_tag[23:0], beat_byte};
   assign remain_dec = cur_remain - 32'd1;

   always_comb begin
      remain_new = cur_remain;
      if (cur_hdr_cnt == 4'd4) begin
         remain_new = {24'd0, beat_byte};
      end else begin
         remain_new[{cur_hdr_cnt[1:0], 3'b000} +: 8] = beat_byte;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      riff_len_in  = riff_len_ff;
      file_pos_in  = file_pos_ff;
      tag_in       = tag_ff;
      remain_in    = remain_ff;
      fmt_in       = fmt_ff;
      low_in       = low_ff;
      phase_bit_in = phase_bit_ff;
      res          = '0;
      have         = 1'b0;
      err          = 1'b0;
      fin          = 1'b0;
      ecode        = ERR_NONE;
      q_push       = 1'b0;

      if (accept) begin
         phase_in     = cur_phase;
         hdr_cnt_in   = cur_hdr_cnt;
         riff_len_in  = cur_riff_len;
         file_pos_in  = cur_file_pos;
         tag_in       = cur_tag;
         remain_in    = cur_remain;
         fmt_in       = cur_fmt;
         low_in       = cur_low;
         phase_bit_in = cur_phase_bit;

         if (cur_phase != PH_HALT) begin
            file_pos_in = pos_inc;
            unique case (cur_phase)
               PH_FILEHDR: begin
                  riff_len_in = riff_upd;
                  if (cur_hdr_cnt[3:2] != 2'b01) begin
                     tag_in = tag_new;
                  end
                  if (cur_hdr_cnt == 4'd3 && tag_new != TAG_RIFF) begin
                     err   = 1'b1;
                     ecode = ERR_BAD_RIFF;
                  end else if (cur_hdr_cnt >= 4'd11) begin
                     if (tag_new != TAG_WAVE) begin
                        err   = 1'b1;
                        ecode = ERR_BAD_WAVE;
                     end else begin
                        fin        = span_done;
                        phase_in   = span_done ? PH_HALT : PH_CHUNKHDR;
                        hdr_cnt_in = 4'd0;
                     end
                  end else begin
                     hdr_cnt_in = cur_hdr_cnt + 4'd1;
                  end
               end
               PH_CHUNKHDR: begin
                  if (cur_hdr_cnt < 4'd4) begin
                     tag_in = tag_new;
                  end else begin
                     remain_in = remain_new;
                  end
                  if (cur_hdr_cnt < 4'd7) begin
                     hdr_cnt_in = cur_hdr_cnt + 4'd1;
                  end else begin
                     hdr_cnt_in = 4'd0;
                     if (cur_tag == TAG_FMT) begin
                        if (remain_new == 32'd0) begin
                           res.kind            = KIND_FORMAT;
                           res.audio_format    = cur_fmt[15:0];
                           res.channels        = cur_fmt[31:16];
                           res.sample_rate     = cur_fmt[63:32];
                           res.byte_rate       = cur_fmt[95:64];
                           res.block_align     = cur_fmt[111:96];
                           res.bits_per_sample = cur_fmt[127:112];
                           have                = 1'b1;
                           fin                 = span_done;
                           phase_in            = span_done ? PH_HALT : PH_CHUNKHDR;
                        end else begin
                           phase_in = PH_FMT;
                        end
                     end else if (cur_tag == TAG_DATA) begin
                        if (cur_fmt[127:112] != PCM16_BITS) begin
                           err   = 1'b1;
                           ecode = ERR_BAD_DEPTH;
                        end else begin
                           remain_in    = remain_new & 32'hFFFF_FFFE;
                           phase_bit_in = 1'b0;
                           if (remain_new[31:1] == 31'd0) begin
                              fin      = span_done;
                              phase_in = span_done ? PH_HALT : PH_CHUNKHDR;
                           end else begin
                              phase_in = PH_DATA;
                           end
                        end
                     end else begin
                        if (remain_new == 32'd0) begin
                           fin      = span_done;
                           phase_in = span_done ? PH_HALT : PH_CHUNKHDR;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                  end
               end
               PH_FMT: begin
                  fmt_in[{cur_hdr_cnt, 3'b000} +: 8] = beat_byte;
                  remain_in = remain_dec;
                  if (cur_hdr_cnt == FMT_LAST_INDEX || remain_dec == 32'd0) begin
                     res.kind            = KIND_FORMAT;
                     res.audio_format    = fmt_in[15:0];
                     res.channels        = fmt_in[31:16];
                     res.sample_rate     = fmt_in[63:32];
                     res.byte_rate       = fmt_in[95:64];
                     res.block_align     = fmt_in[111:96];
                     res.bits_per_sample = fmt_in[127:112];
                     have                = 1'b1;
                     hdr_cnt_in          = 4'd0;
                     if (remain_dec == 32'd0) begin
                        fin      = span_done;
                        phase_in = span_done ? PH_HALT : PH_CHUNKHDR;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     hdr_cnt_in = cur_hdr_cnt + 4'd1;
                  end
               end
               PH_SKIP: begin
                  remain_in = remain_dec;
                  if (remain_dec == 32'd0) begin
                     fin        = span_done;
                     phase_in   = span_done ? PH_HALT : PH_CHUNKHDR;
                     hdr_cnt_in = 4'd0;
                  end
               end
               PH_DATA: begin
                  remain_in = remain_dec;
                  if (!cur_phase_bit) begin
                     low_in       = beat_byte;
                     phase_bit_in = 1'b1;
                  end else begin
                     phase_bit_in = 1'b0;
                     res.kind     = KIND_SAMPLE;
                     res.sample   = {beat_byte, cur_low};
                     have         = 1'b1;
                  end
                  if (remain_dec == 32'd0) begin
                     fin        = span_done;
                     phase_in   = span_done ? PH_HALT : PH_CHUNKHDR;
                     hdr_cnt_in = 4'd0;
                  end
               end
               default: begin
                  phase_in = PH_HALT;
               end
            endcase

            if (err) begin
               res            = '0;
               res.kind       = KIND_ERROR;
               res.error_code = ecode;
               phase_in       = PH_HALT;
               have           = 1'b1;
            end else if (fin) begin
               if (!have) begin
                  res.kind = KIND_DONE;
               end
               res.last = 1'b1;
               have     = 1'b1;
            end else if (req_chan.end_of_file) begin
               res            = '0;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_TRUNCATED;
               phase_in       = PH_HALT;
               have           = 1'b1;
            end
            q_push = have;
         end
      end
   end

   assign q_push_data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FILEHDR;
         hdr_cnt_ff   <= 4'd0;
         riff_len_ff  <= 32'd0;
         file_pos_ff  <= 33'd0;
         tag_ff       <= 32'd0;
         remain_ff    <= 32'd0;
         fmt_ff       <= 128'd0;
         low_ff       <= 8'd0;
         phase_bit_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         riff_len_ff  <= riff_len_in;
         file_pos_ff  <= file_pos_in;
         tag_ff       <= tag_in;
         remain_ff    <= remain_in;
         fmt_ff       <= fmt_in;
         low_ff       <= low_in;
         phase_bit_ff <= phase_bit_in;
      end
   end

endmodule

`default_nettype wire

### sv/wrcp_queue.sv
// ----------------------------------------------------------------------------
// wrcp_queue
// small result fifo between the chunk walker and the output stage
// ----------------------------------------------------------------------------
`default_nettype none

module wrcp_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire wrcp_pkg::wrcp_result_type        push_data,
   input  wire logic                             pop,
   output wrcp_pkg::wrcp_result_type             head_data,
   output wrcp_pkg::wrcp_queue_status_type       status
);
   import wrcp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   wrcp_result_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### sv/wrcp_back.sv
// ----------------------------------------------------------------------------
// wrcp_back
// output register that drains the result queue onto the response channel
// ----------------------------------------------------------------------------
`default_nettype none

module wrcp_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire wrcp_pkg::wrcp_result_type        head_data,
   input  wire wrcp_pkg::wrcp_queue_status_type  q_status,
   output logic                                  q_pop,
   wrcp_rsp_if.source                            rsp_chan
);
   import wrcp_pkg::*;

   logic            out_valid_ff, out_valid_in;
   wrcp_result_type out_data_ff;

   assign q_pop = !q_status.empty && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_data_ff <= head_data;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.kind            = 2'(out_data_ff.kind);
   assign rsp_chan.sample          = out_data_ff.sample;
   assign rsp_chan.audio_format    = out_data_ff.audio_format;
   assign rsp_chan.channels        = out_data_ff.channels;
   assign rsp_chan.sample_rate     = out_data_ff.sample_rate;
   assign rsp_chan.byte_rate       = out_data_ff.byte_rate;
   assign rsp_chan.block_align     = out_data_ff.block_align;
   assign rsp_chan.bits_per_sample = out_data_ff.bits_per_sample;
   assign rsp_chan.error_code      = 3'(out_data_ff.error_code);
   assign rsp_chan.last            = out_data_ff.last;

endmodule

`default_nettype wire

### sv/wav_riff_chunk_parser_core.sv
// ----------------------------------------------------------------------------
// wav_riff_chunk_parser_core
// byte-serial riff/wave parser giving format records and 16-bit pcm samples
// ----------------------------------------------------------------------------
// Takes one byte of a WAV file per clock cycle while the result queue is not
// full and gives at most one result per byte: a format record, a signed
// 16-bit sample, an error or a done marker. The chunk walker classifies each
// byte in the cycle it is accepted and writes any result into a small queue;
// an output register drains the queue onto the response channel, so a result
// passes through the queue and then the output register. The request side
// stays ready unless QUEUE_DEPTH results are waiting behind a stalled
// response channel. After an error or the end of the RIFF span, bytes are
// swallowed without result until one with first_byte set.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_riff_chunk_parser_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   wrcp_req_if.sink   req_chan,
   wrcp_rsp_if.source rsp_chan
);
   import wrcp_pkg::*;

   `include "wav_riff_chunk_parser_core_assert.svh"

   logic                  q_push;
   logic                  q_pop;
   logic                  req_beat;
   wrcp_result_type       q_push_data;
   wrcp_result_type       q_head_data;
   wrcp_queue_status_type q_status;

   assign req_beat = req_chan.valid && req_chan.ready;

   wrcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   wrcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head_data),
      .status    (q_status)
   );

   wrcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (q_head_data),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_chan  (rsp_chan)
   );

   `WRCP_ASSERT_IMPLY(a_push_not_full, clock, reset, q_push, !q_status.full, "push when full")
   `WRCP_ASSERT_IMPLY(a_push_on_beat, clock, reset, q_push, req_beat, "push without beat")
   `WRCP_ASSERT_NEXT(a_queue_drains, clock, reset, !q_status.empty, rsp_chan.valid, "no drain")

endmodule

`default_nettype wire
